// File: sv/bpt_pkg.sv
// Package for the breakpoint table: sizes, opcodes, transaction structs,
// controller state type and controller/datapath command and status groups.
// No dependencies.
package bpt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DELETE    = 3'd2;
  localparam logic [2:0] OP_SET_FLAG  = 3'd3;
  localparam logic [2:0] OP_LOOKUP    = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] bp_address;
    logic [7:0]  saved_byte;
    logic        new_flag;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [7:0]       found_byte;
    logic             found_active;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;    // capture the request transaction
    logic search;  // register the first-match position
    logic exec;    // update the table and load the response register
  } cmd_t;

  typedef struct packed {
    logic rsp_busy;  // response register holds a transaction that is stalled
  } status_t;

endpackage

// File: sv/breakpoint_table.sv
// Top level of the breakpoint table: joins bpt_ctrl and bpt_datapath.
// Depends on bpt_pkg, bpt_ctrl, bpt_datapath.
//
//   channel   handshake                  payload
//   request   req_valid / req_stall      req (req_t)
//   response  rsp_valid / rsp_stall      rsp (rsp_t)
//
// Each request passes through a search step, which registers the first-match
// position from the parallel address compare, and an execute step, which updates the entry registers.
// A new request is taken in the execute cycle, so back-to-back requests
// overlap one request's execute with the next one's capture while the response register drains.
// Reset empties the table (count zero) and clears the response valid.
// A stalled response holds the next request in execute until it is taken.
module breakpoint_table import bpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: sv/bpt_ctrl.sv
// Controller for the breakpoint table: idle / search / execute sequencing.
// Depends on bpt_pkg.
module bpt_ctrl import bpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    take       = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        take      = req_valid;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the response register can take the result
        if (!status.rsp_busy) begin
          cmd.exec   = 1'b1;
          req_stall  = 1'b0;
          take       = req_valid;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (take) begin
      cmd.load   = 1'b1;
      state_next = ST_SEARCH;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(state) == ST_SEARCH || $past(state) == ST_EXEC)
    else $error("execute without a preceding search");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_SEARCH)
    else $error("accepted request did not start a search");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status.rsp_busy) == 1'b0)
    else $error("execute while response register is stalled");

endmodule

// File: sv/bpt_datapath.sv
// Datapath for the breakpoint table: request register, entry registers,
// parallel address compare, shift update and response register. Uses bpt_pkg.
module bpt_datapath import bpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  req_t             cur;
  logic [31:0]      addr_q [DEPTH];
  logic [7:0]       byte_q [DEPTH];
  logic             act_q  [DEPTH];
  logic [31:0]      addr_next [DEPTH];
  logic [7:0]       byte_next [DEPTH];
  logic             act_next  [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [DEPTH-1:0] hit_vec;
  logic [IDX_W-1:0] hit_idx_c;
  logic [IDX_W-1:0] match_idx;
  logic             match_hit;
  logic             not_full;
  rsp_t             rsp_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  // first match in list order among occupied positions
  always_comb begin
    hit_idx_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i] = (CNT_W'(i) < count) && (addr_q[i] == cur.bp_address);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx_c = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_idx <= hit_idx_c;
      match_hit <= |hit_vec;
    end
  end

  assign not_full = count < CNT_W'(DEPTH);

  always_comb begin
    count_next = count;
    rsp_next   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      addr_next[i] = addr_q[i];
      byte_next[i] = byte_q[i];
      act_next[i]  = act_q[i];
    end
    case (cur.opcode)
      OP_INS_FRONT: begin
        if (not_full) begin
          for (int i = 1; i < DEPTH; i++) begin
            addr_next[i] = addr_q[i-1];
            byte_next[i] = byte_q[i-1];
            act_next[i]  = act_q[i-1];
          end
          addr_next[0]     = cur.bp_address;
          byte_next[0]     = cur.saved_byte;
          act_next[0]      = 1'b1;
          count_next       = count + 1'b1;
          rsp_next.success = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (not_full) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) == count[IDX_W-1:0]) begin
              addr_next[i] = cur.bp_address;
              byte_next[i] = cur.saved_byte;
              act_next[i]  = 1'b1;
            end
          end
          count_next       = count + 1'b1;
          rsp_next.success = 1'b1;
        end
      end
      OP_DELETE: begin
        if (match_hit) begin
          // close the gap: later entries advance one place
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= match_idx) begin
              addr_next[i] = addr_q[i+1];
              byte_next[i] = byte_q[i+1];
              act_next[i]  = act_q[i+1];
            end
          end
          count_next       = count - 1'b1;
          rsp_next.success = 1'b1;
        end
      end
      OP_SET_FLAG: begin
        if (match_hit) begin
          act_next[match_idx] = cur.new_flag;
          rsp_next.success    = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (match_hit) begin
          rsp_next.found_byte   = byte_q[match_idx];
          rsp_next.found_active = act_q[match_idx];
          rsp_next.success      = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next       = '0;
        rsp_next.success = 1'b1;
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        addr_q[i] <= addr_next[i];
        byte_q[i] <= byte_next[i];
        act_q[i]  <= act_next[i];
      end
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status.rsp_busy = rsp_valid && rsp_stall;

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.exec) |-> $stable(count) || $past(rst))
    else $error("entry count changed without an execute");

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp.entry_count == count)
    else $error("response count disagrees with table count");

  assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> !$past(rsp_stall))
    else $error("response dropped while stalled");

endmodule

// File: verif/tb.sv
// Self-checking testbench for breakpoint_table: directed and random command
// streams, checked against a shadow table kept inside this module.
// Depends on bpt_pkg and the breakpoint_table RTL.
module tb import bpt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  breakpoint_table dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Shadow copy of the breakpoint table
  logic [31:0] shadow_addr [DEPTH];
  logic [7:0]  shadow_byte [DEPTH];
  logic        shadow_active [DEPTH];
  int          shadow_count = 0;

  rsp_t rsp_due [$];
  int errors = 0;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [31:0] addr_pool [POOL_SIZE];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // First entry in list order whose address matches, or shadow_count on a miss.
  function automatic int find_first(logic [31:0] addr);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_addr[i] == addr) return i;
    end
    return shadow_count;
  endfunction

  // Apply one command to the shadow table and return the response it must produce.
  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int pos;
    o = '0;
    case (r.opcode)
      OP_INS_FRONT: begin
        if (shadow_count < DEPTH) begin
          for (int i = shadow_count; i > 0; i--) begin
            shadow_addr[i] = shadow_addr[i-1];
            shadow_byte[i] = shadow_byte[i-1];
            shadow_active[i] = shadow_active[i-1];
          end
          shadow_addr[0] = r.bp_address;
          shadow_byte[0] = r.saved_byte;
          shadow_active[0] = 1'b1;
          shadow_count++;
          o.success = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (shadow_count < DEPTH) begin
          shadow_addr[shadow_count] = r.bp_address;
          shadow_byte[shadow_count] = r.saved_byte;
          shadow_active[shadow_count] = 1'b1;
          shadow_count++;
          o.success = 1'b1;
        end
      end
      OP_DELETE: begin
        pos = find_first(r.bp_address);
        if (pos < shadow_count) begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_addr[i] = shadow_addr[i+1];
            shadow_byte[i] = shadow_byte[i+1];
            shadow_active[i] = shadow_active[i+1];
          end
          shadow_count--;
          o.success = 1'b1;
        end
      end
      OP_SET_FLAG: begin
        pos = find_first(r.bp_address);
        if (pos < shadow_count) begin
          shadow_active[pos] = r.new_flag;
          o.success = 1'b1;
        end
      end
      OP_LOOKUP: begin
        pos = find_first(r.bp_address);
        if (pos < shadow_count) begin
          o.found_byte = shadow_byte[pos];
          o.found_active = shadow_active[pos];
          o.success = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        o.success = 1'b1;
      end
      default: ;
    endcase
    o.entry_count = CNT_W'(shadow_count);
    return o;
  endfunction

  function automatic req_t cmd(logic [2:0] op, logic [31:0] addr, logic [7:0] b, logic f);
    req_t r;
    r.opcode = op;
    r.bp_address = addr;
    r.saved_byte = b;
    r.new_flag = f;
    return r;
  endfunction

  function automatic req_t random_cmd();
    req_t r;
    int w;
    w = $urandom_range(99);
    if (w < 22)      r.opcode = OP_INS_FRONT;
    else if (w < 44) r.opcode = OP_INS_BACK;
    else if (w < 64) r.opcode = OP_DELETE;
    else if (w < 74) r.opcode = OP_SET_FLAG;
    else if (w < 94) r.opcode = OP_LOOKUP;
    else if (w < 97) r.opcode = OP_CLEAR;
    else             r.opcode = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
    // Mostly pool addresses so keys hit and duplicates pile up
    if ($urandom_range(99) < 85) r.bp_address = addr_pool[$urandom_range(POOL_SIZE-1)];
    else                         r.bp_address = $urandom;
    r.saved_byte = 8'($urandom_range(255));
    r.new_flag = 1'($urandom_range(1));
    return r;
  endfunction

  // Offer one transaction, hold it until taken, then record what it must return.
  task automatic send_cmd(req_t r);
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    rsp_due.push_back(apply_command(r));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int g, int s);
    gap_pct = g;
    stall_pct <= s;
  endtask

  task automatic test_empty_table();
    send_cmd(cmd(OP_LOOKUP, 32'h0000_0000, 8'h00, 1'b0));
    send_cmd(cmd(OP_DELETE, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_cmd(cmd(OP_SET_FLAG, 32'h0000_0000, 8'h00, 1'b1));
    drain();
  endtask

  task automatic test_order_and_duplicates();
    send_cmd(cmd(OP_INS_BACK, 32'h0000_0000, 8'h00, 1'b0));
    send_cmd(cmd(OP_INS_FRONT, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    send_cmd(cmd(OP_INS_BACK, 32'hFFFF_FFFF, 8'h5A, 1'b1));
    send_cmd(cmd(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0));
    send_cmd(cmd(OP_SET_FLAG, 32'hFFFF_FFFF, 8'h00, 1'b0));
    send_cmd(cmd(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0));
    // Delete takes the front copy; the back duplicate becomes visible
    send_cmd(cmd(OP_DELETE, 32'hFFFF_FFFF, 8'h00, 1'b0));
    send_cmd(cmd(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0));
    send_cmd(cmd(OP_LOOKUP, 32'h0000_0000, 8'hFF, 1'b1));
    send_cmd(cmd(OP_UNUSED_6, 32'h0000_0000, 8'h00, 1'b1));
    send_cmd(cmd(OP_UNUSED_7, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    drain();
  endtask

  task automatic test_full_table();
    while (shadow_count < DEPTH - 1)
      send_cmd(cmd(OP_INS_BACK, 32'h1000_0000 + shadow_count, 8'(shadow_count * 17), 1'b0));
    send_cmd(cmd(OP_INS_FRONT, 32'hCAFE_0000, 8'hA5, 1'b0));
    send_cmd(cmd(OP_INS_BACK, 32'hCAFE_0001, 8'h3C, 1'b0));
    send_cmd(cmd(OP_INS_FRONT, 32'hCAFE_0002, 8'hC3, 1'b0));
    send_cmd(cmd(OP_LOOKUP, 32'h1000_0002, 8'h00, 1'b0));
    send_cmd(cmd(OP_DELETE, 32'hCAFE_0000, 8'h00, 1'b0));
    send_cmd(cmd(OP_CLEAR, 32'h0000_0000, 8'h00, 1'b0));
    send_cmd(cmd(OP_LOOKUP, 32'h1000_0002, 8'h00, 1'b0));
    drain();
  endtask

  task automatic test_random(int gap, int stall, int n);
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    set_idling(gap, stall);
    for (int i = 0; i < n; i++) send_cmd(random_cmd());
    drain();
  endtask

  // Hold the response side long enough for the block to fill and stall requests.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 30; i++) send_cmd(random_cmd());
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("response transaction with nothing expected: %h", rsp);
        errors++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, rsp.success);
          errors++;
        end
        if (rsp.found_byte !== want.found_byte) begin
          $error("found_byte: expected %h, got %h", want.found_byte, rsp.found_byte);
          errors++;
        end
        if (rsp.found_active !== want.found_active) begin
          $error("found_active: expected %0d, got %0d", want.found_active, rsp.found_active);
          errors++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_order_and_duplicates();
    test_full_table();
    test_random(0, 0, 360);
    test_random(69, 0, 360);
    test_random(0, 69, 360);
    test_backpressure();
    test_random(6, 6, 360);
    set_idling(0, 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bpt_pkg.sv
sv/bpt_ctrl.sv
sv/bpt_datapath.sv
sv/breakpoint_table.sv
verif/tb.sv
